FILE: src/spectral_gate_bin_scaler_macros.svh
// Assertion macros shared by the spectral gate modules.
// Both macros expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef SPECTRAL_GATE_BIN_SCALER_MACROS_SVH
`define SPECTRAL_GATE_BIN_SCALER_MACROS_SVH

`define SGBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sgbs assertion failed");

`define SGBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgbs assertion failed");

`endif

FILE: src/sgbs_pkg.sv
`default_nettype none
package sgbs_pkg;

  localparam int unsigned BINS       = 2048;
  localparam int unsigned ADDR_W     = $clog2(BINS);
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned SUM_W      = 60;
  localparam int unsigned HALF_W     = SUM_W / 2;
  localparam int unsigned PWR_W      = 2 * SAMPLE_W;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned RHS_W      = MUL_W + SUM_W;
  localparam int unsigned Q_SHIFT    = 15;
  // BINS is a power of two, so the factor 2*BINS*2^16 on the power side is a shift.
  localparam int unsigned LHS_SHIFT  = $clog2(2 * BINS) + 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] MIX_RESET  = GAIN_W'(32768);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(3840);

  localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 1'b1;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LWR,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_RD,
    ST_FETCH,
    ST_RRE2,
    ST_RIM2,
    ST_RLO,
    ST_RHI,
    ST_RADD,
    ST_RCMP,
    ST_RSRE,
    ST_RSIM,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_THR,
    MUL_RE2,
    MUL_IM2,
    MUL_LO,
    MUL_HI,
    MUL_REG,
    MUL_IMG
  } mul_sel_e;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_T2,
    ACC_PWR_LD,
    ACC_PWR_ADD,
    ACC_RHS_LD,
    ACC_RHS_HI,
    ACC_SUM,
    ACC_DECIDE,
    ACC_SRE
  } acc_op_e;

  typedef struct packed {
    logic     cap;
    logic     mem_we;
    logic     mem_re;
    logic     fetch;
    logic     out_load;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
  } cmd_t;

  typedef struct packed {
    logic in_action;
    logic in_oor;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: src/sgbs_datapath.sv
`default_nettype none
module sgbs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgbs_pkg::cmd_t                       cmd_i,
  output sgbs_pkg::status_t                    status_o,
  input  logic [sgbs_pkg::IN_DATA_W-1:0]       in_data_i,
  input  logic [sgbs_pkg::IN_USER_W-1:0]       in_user_i,
  input  logic                                 cfg_we_i,
  input  logic [sgbs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [15:0]                          cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sgbs_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic                                 out_loud_o
);

  localparam int unsigned SW = sgbs_pkg::SAMPLE_W;

  logic [sgbs_pkg::GAIN_W-1:0] mix_q;
  logic [sgbs_pkg::THR_W-1:0]  thr_q;

  logic [sgbs_pkg::IDX_W-1:0]  idx_q;
  logic signed [SW-1:0]        re_q, im_q;
  logic                        fs_q, oor_q;

  logic [2*SW-1:0]             mem [sgbs_pkg::BINS];
  logic [2*SW-1:0]             rd_q;

  logic [sgbs_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [sgbs_pkg::PROD_W-1:0] prod, p_q;
  logic [sgbs_pkg::MUL_W-1:0]  t2_q;
  logic [sgbs_pkg::PWR_W-1:0]  pwr_q;
  logic [sgbs_pkg::RHS_W-1:0]  rhs_q, lhs;
  logic [sgbs_pkg::SUM_W-1:0]  sum_q, sum_base;
  logic [sgbs_pkg::SUM_W:0]    sum_add;
  logic [SW-1:0]               sre_q, sim, mag_re, mag_im;
  logic [sgbs_pkg::GAIN_W-1:0] gain_q, beta;
  logic                        loud_q, loud;

  logic                        out_valid_q, out_loud_q;
  logic [SW-1:0]               out_re_q, out_im_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q <= sgbs_pkg::MIX_RESET;
      thr_q <= sgbs_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sgbs_pkg::CFG_MIX_GAIN: mix_q <= cfg_data_i;
        sgbs_pkg::CFG_THRESH:   thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign status_o.in_action = in_user_i[0];
  assign status_o.in_oor    = ({1'b0, in_data_i[sgbs_pkg::IDX_W-1:0]} >=
                               (sgbs_pkg::IDX_W + 1)'(sgbs_pkg::BINS));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Operand registers, loaded from the input transaction or from the bin memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      idx_q <= in_data_i[sgbs_pkg::IDX_W-1:0];
      re_q  <= in_data_i[sgbs_pkg::IDX_W +: SW];
      im_q  <= in_data_i[sgbs_pkg::IDX_W + SW +: SW];
      fs_q  <= in_user_i[1];
      oor_q <= status_o.in_oor;
    end else if (cmd_i.fetch) begin
      re_q <= rd_q[SW-1:0];
      im_q <= rd_q[2*SW-1:SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[idx_q[sgbs_pkg::ADDR_W-1:0]] <= {im_q, re_q};
    end
    if (cmd_i.mem_re) begin
      rd_q <= mem[idx_q[sgbs_pkg::ADDR_W-1:0]];
    end
  end

  assign mag_re = re_q[SW-1] ? SW'(-re_q) : SW'(re_q);
  assign mag_im = im_q[SW-1] ? SW'(-im_q) : SW'(im_q);

  // One shared multiplier with a product register.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      sgbs_pkg::MUL_THR: begin
        mul_a = sgbs_pkg::MUL_W'(thr_q);
        mul_b = sgbs_pkg::MUL_W'(thr_q);
      end
      sgbs_pkg::MUL_RE2: begin
        mul_a = sgbs_pkg::MUL_W'(mag_re);
        mul_b = sgbs_pkg::MUL_W'(mag_re);
      end
      sgbs_pkg::MUL_IM2: begin
        mul_a = sgbs_pkg::MUL_W'(mag_im);
        mul_b = sgbs_pkg::MUL_W'(mag_im);
      end
      sgbs_pkg::MUL_LO: begin
        mul_a = t2_q;
        mul_b = sgbs_pkg::MUL_W'(sum_q[sgbs_pkg::HALF_W-1:0]);
      end
      sgbs_pkg::MUL_HI: begin
        mul_a = t2_q;
        mul_b = sgbs_pkg::MUL_W'(sum_q[sgbs_pkg::SUM_W-1:sgbs_pkg::HALF_W]);
      end
      sgbs_pkg::MUL_REG: begin
        mul_a = sgbs_pkg::MUL_W'(mag_re);
        mul_b = sgbs_pkg::MUL_W'(gain_q);
      end
      sgbs_pkg::MUL_IMG: begin
        mul_a = sgbs_pkg::MUL_W'(mag_im);
        mul_b = sgbs_pkg::MUL_W'(gain_q);
      end
      default: ;
    endcase
  end

  assign prod = sgbs_pkg::PROD_W'(mul_a) * sgbs_pkg::PROD_W'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != sgbs_pkg::MUL_NONE) begin
      p_q <= prod;
    end
  end

  // Frame power sum, cleared by a frame start and saturating at all ones.
  assign sum_base = fs_q ? '0 : sum_q;
  assign sum_add  = {1'b0, sum_base} + (sgbs_pkg::SUM_W + 1)'(pwr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.acc_op == sgbs_pkg::ACC_SUM) begin
      sum_q <= sum_add[sgbs_pkg::SUM_W] ? '1 : sum_add[sgbs_pkg::SUM_W-1:0];
    end
  end

  assign lhs  = sgbs_pkg::RHS_W'(pwr_q) << sgbs_pkg::LHS_SHIFT;
  assign loud = (lhs >= rhs_q);
  assign beta = (mix_q > sgbs_pkg::UNITY_GAIN) ? sgbs_pkg::UNITY_GAIN : mix_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      sgbs_pkg::ACC_T2:      t2_q  <= p_q[sgbs_pkg::MUL_W-1:0];
      sgbs_pkg::ACC_PWR_LD:  pwr_q <= p_q[sgbs_pkg::PWR_W-1:0];
      sgbs_pkg::ACC_PWR_ADD: pwr_q <= pwr_q + p_q[sgbs_pkg::PWR_W-1:0];
      sgbs_pkg::ACC_RHS_LD:  rhs_q <= sgbs_pkg::RHS_W'(p_q);
      sgbs_pkg::ACC_RHS_HI:  rhs_q <= rhs_q + (sgbs_pkg::RHS_W'(p_q) << sgbs_pkg::HALF_W);
      sgbs_pkg::ACC_DECIDE: begin
        loud_q <= loud;
        gain_q <= loud ? beta : sgbs_pkg::UNITY_GAIN - beta;
      end
      sgbs_pkg::ACC_SRE:     sre_q <= p_q[sgbs_pkg::Q_SHIFT +: SW];
      default: ;
    endcase
  end

  // The imaginary product is still held in the product register here.
  assign sim = p_q[sgbs_pkg::Q_SHIFT +: SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (oor_q) begin
        out_re_q   <= '0;
        out_im_q   <= '0;
        out_loud_q <= 1'b0;
      end else begin
        out_re_q   <= re_q[SW-1] ? SW'(-sre_q) : sre_q;
        out_im_q   <= im_q[SW-1] ? SW'(-sim) : sim;
        out_loud_q <= loud_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_im_q, out_re_q};
  assign out_loud_o  = out_loud_q;

endmodule
`default_nettype wire

FILE: src/sgbs_ctrl.sv
`default_nettype none
`include "spectral_gate_bin_scaler_macros.svh"
module sgbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sgbs_pkg::status_t status_i,
  output sgbs_pkg::cmd_t    cmd_o
);

  sgbs_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sgbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (status_i.in_action == sgbs_pkg::ACTION_READ) begin
            state_d = status_i.in_oor ? sgbs_pkg::ST_OUT : sgbs_pkg::ST_RD;
          end else begin
            // A load with an out-of-range index is dropped without touching the sum.
            state_d = status_i.in_oor ? sgbs_pkg::ST_IDLE : sgbs_pkg::ST_LWR;
          end
        end
      end
      sgbs_pkg::ST_LWR:   state_d = sgbs_pkg::ST_L1;
      sgbs_pkg::ST_L1:    state_d = sgbs_pkg::ST_L2;
      sgbs_pkg::ST_L2:    state_d = sgbs_pkg::ST_L3;
      sgbs_pkg::ST_L3:    state_d = sgbs_pkg::ST_IDLE;
      sgbs_pkg::ST_RD:    state_d = sgbs_pkg::ST_FETCH;
      sgbs_pkg::ST_FETCH: state_d = sgbs_pkg::ST_RRE2;
      sgbs_pkg::ST_RRE2:  state_d = sgbs_pkg::ST_RIM2;
      sgbs_pkg::ST_RIM2:  state_d = sgbs_pkg::ST_RLO;
      sgbs_pkg::ST_RLO:   state_d = sgbs_pkg::ST_RHI;
      sgbs_pkg::ST_RHI:   state_d = sgbs_pkg::ST_RADD;
      sgbs_pkg::ST_RADD:  state_d = sgbs_pkg::ST_RCMP;
      sgbs_pkg::ST_RCMP:  state_d = sgbs_pkg::ST_RSRE;
      sgbs_pkg::ST_RSRE:  state_d = sgbs_pkg::ST_RSIM;
      sgbs_pkg::ST_RSIM:  state_d = sgbs_pkg::ST_OUT;
      sgbs_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          state_d = sgbs_pkg::ST_IDLE;
        end
      end
      default: state_d = sgbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_sel  = sgbs_pkg::MUL_NONE;
    cmd_o.acc_op   = sgbs_pkg::ACC_NONE;
    case (state_q)
      sgbs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      sgbs_pkg::ST_LWR: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.mul_sel = sgbs_pkg::MUL_RE2;
      end
      sgbs_pkg::ST_L1: begin
        cmd_o.mul_sel = sgbs_pkg::MUL_IM2;
        cmd_o.acc_op  = sgbs_pkg::ACC_PWR_LD;
      end
      sgbs_pkg::ST_L2: cmd_o.acc_op = sgbs_pkg::ACC_PWR_ADD;
      sgbs_pkg::ST_L3: cmd_o.acc_op = sgbs_pkg::ACC_SUM;
      sgbs_pkg::ST_RD: begin
        cmd_o.mem_re  = 1'b1;
        cmd_o.mul_sel = sgbs_pkg::MUL_THR;
      end
      sgbs_pkg::ST_FETCH: begin
        cmd_o.fetch  = 1'b1;
        cmd_o.acc_op = sgbs_pkg::ACC_T2;
      end
      sgbs_pkg::ST_RRE2: cmd_o.mul_sel = sgbs_pkg::MUL_RE2;
      sgbs_pkg::ST_RIM2: begin
        cmd_o.mul_sel = sgbs_pkg::MUL_IM2;
        cmd_o.acc_op  = sgbs_pkg::ACC_PWR_LD;
      end
      sgbs_pkg::ST_RLO: begin
        cmd_o.mul_sel = sgbs_pkg::MUL_LO;
        cmd_o.acc_op  = sgbs_pkg::ACC_PWR_ADD;
      end
      sgbs_pkg::ST_RHI: begin
        cmd_o.mul_sel = sgbs_pkg::MUL_HI;
        cmd_o.acc_op  = sgbs_pkg::ACC_RHS_LD;
      end
      sgbs_pkg::ST_RADD: cmd_o.acc_op = sgbs_pkg::ACC_RHS_HI;
      sgbs_pkg::ST_RCMP: cmd_o.acc_op = sgbs_pkg::ACC_DECIDE;
      sgbs_pkg::ST_RSRE: cmd_o.mul_sel = sgbs_pkg::MUL_REG;
      sgbs_pkg::ST_RSIM: begin
        cmd_o.mul_sel = sgbs_pkg::MUL_IMG;
        cmd_o.acc_op  = sgbs_pkg::ACC_SRE;
      end
      sgbs_pkg::ST_OUT: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  `SGBS_ASSERT(a_mem_one_port, !(cmd_o.mem_we && cmd_o.mem_re))
  `SGBS_ASSERT_NEXT(a_load_starts,
    accept && (status_i.in_action == sgbs_pkg::ACTION_LOAD) && !status_i.in_oor,
    state_q == sgbs_pkg::ST_LWR)
  `SGBS_ASSERT(a_sum_after_power,
    (cmd_o.acc_op == sgbs_pkg::ACC_SUM) |-> ($past(cmd_o.acc_op) == sgbs_pkg::ACC_PWR_ADD))
  `SGBS_ASSERT_NEXT(a_result_follows, state_q == sgbs_pkg::ST_RSIM, state_q == sgbs_pkg::ST_OUT)

endmodule
`default_nettype wire

FILE: src/spectral_gate_bin_scaler.sv
// A load passes through LWR, L1, L2 and L3 before the next transaction can be accepted.
// A read passes through RD, FETCH, RRE2, RIM2, RLO, RHI, RADD, RCMP, RSRE and RSIM; the result
// enters the output register in OUT once it is free and may wait there while the next one is taken in.
// The steps share one 32x32 multiplier; a read out of range goes from IDLE straight to OUT.
// Reset clears the controller, sets both registers to their defaults and zeroes the
// frame power sum; the bin memory is not cleared and holds garbage until written.
`default_nettype none
module spectral_gate_bin_scaler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // bin_index[10:0], real_part[34:11], imag_part[58:35], zero fill [63:59]
  input  logic [sgbs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // action[0], frame_start[1]
  input  logic [sgbs_pkg::IN_USER_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // real_out[23:0], imag_out[47:24]
  output logic [sgbs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // is_loud[0]
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sgbs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [15:0]                          cfg_data_i
);

  sgbs_pkg::cmd_t    cmd;
  sgbs_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  sgbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sgbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_loud_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire

FILE: tb/spectral_gate_bin_scaler_checker.sv
`timescale 1ns / 100ps
module spectral_gate_bin_scaler_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [sgbs_pkg::IN_DATA_W-1:0]  s_data_i,
  input  logic [sgbs_pkg::IN_USER_W-1:0]  s_user_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [sgbs_pkg::OUT_DATA_W-1:0] m_data_i,
  input  logic                            m_user_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [sgbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              loud_count_o,
  output int                              quiet_count_o
);

  localparam int unsigned SW = sgbs_pkg::SAMPLE_W;
  localparam int unsigned GW = sgbs_pkg::GAIN_W;
  localparam int unsigned IW = sgbs_pkg::IDX_W;
  localparam int unsigned UW = sgbs_pkg::SUM_W;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 loud;
  } scaled_bin_t;

  localparam logic [UW-1:0] POWER_CEILING = '1;

  logic signed [SW-1:0]          stored_re [sgbs_pkg::BINS];
  logic signed [SW-1:0]          stored_im [sgbs_pkg::BINS];
  logic [UW-1:0]                 frame_power;
  logic [GW-1:0]                 beta_reg;
  logic [sgbs_pkg::THR_W-1:0]    thresh_reg;
  scaled_bin_t                   expected_bins [$];
  scaled_bin_t                   want_bin;
  scaled_bin_t                   got_bin;
  logic [IW-1:0]                 in_idx;
  logic [UW:0]                   sum_next;

  function automatic logic [SW-1:0] magnitude(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic [sgbs_pkg::PWR_W-1:0] bin_energy(input logic signed [SW-1:0] re,
                                                            input logic signed [SW-1:0] im);
    logic [sgbs_pkg::PWR_W-1:0] mr;
    logic [sgbs_pkg::PWR_W-1:0] mi;
    mr = magnitude(re);
    mi = magnitude(im);
    return mr * mr + mi * mi;
  endfunction

  // Magnitude times gain, shifted down, then the sign put back: truncation toward zero.
  function automatic logic signed [SW-1:0] apply_gain(input logic signed [SW-1:0] v,
                                                      input logic [GW-1:0] g);
    logic [SW+GW-1:0] prod;
    prod = ((SW + GW)'(magnitude(v)) * (SW + GW)'(g)) >> sgbs_pkg::Q_SHIFT;
    return v[SW-1] ? -prod[SW-1:0] : prod[SW-1:0];
  endfunction

  function automatic scaled_bin_t gate_bin(input logic [IW-1:0] idx);
    logic [127:0]  lhs;
    logic [127:0]  rhs;
    logic [GW-1:0] beta;
    logic [GW-1:0] g;
    scaled_bin_t   r;
    // Cross-multiplied form of power >= thresh^2 * sum / (2 * BINS), thresh in Q8.8.
    lhs = 128'(bin_energy(stored_re[idx], stored_im[idx]))
        * (128'(2 * sgbs_pkg::BINS) << 16);
    rhs = 128'(thresh_reg) * 128'(thresh_reg) * 128'(frame_power);
    r.loud = (lhs >= rhs);
    beta = (beta_reg > sgbs_pkg::UNITY_GAIN) ? sgbs_pkg::UNITY_GAIN : beta_reg;
    g = r.loud ? beta : sgbs_pkg::UNITY_GAIN - beta;
    r.re = apply_gain(stored_re[idx], g);
    r.im = apply_gain(stored_im[idx], g);
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input int want, input int got);
    fail_count_o++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_power = '0;
      beta_reg = sgbs_pkg::MIX_RESET;
      thresh_reg = sgbs_pkg::THR_RESET;
      expected_bins.delete();
      fail_count_o = 0;
      pending_o = 0;
      loud_count_o = 0;
      quiet_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          sgbs_pkg::CFG_MIX_GAIN: beta_reg = cfg_data_i;
          sgbs_pkg::CFG_THRESH: thresh_reg = cfg_data_i;
          default: ;
        endcase
      end

      if (s_valid_i && s_ready_i) begin
        in_idx = s_data_i[IW-1:0];
        if (s_user_i[0] == sgbs_pkg::ACTION_LOAD) begin
          stored_re[in_idx] = s_data_i[IW +: SW];
          stored_im[in_idx] = s_data_i[IW+SW +: SW];
          if (s_user_i[1]) begin
            frame_power = '0;
          end
          sum_next = {1'b0, frame_power}
                   + (UW + 1)'(bin_energy(stored_re[in_idx], stored_im[in_idx]));
          frame_power = (sum_next > {1'b0, POWER_CEILING}) ? POWER_CEILING
                                                           : sum_next[UW-1:0];
        end else begin
          expected_bins.push_back(gate_bin(in_idx));
        end
      end

      if (m_valid_i && m_ready_i) begin
        got_bin.re = m_data_i[SW-1:0];
        got_bin.im = m_data_i[2*SW-1:SW];
        got_bin.loud = m_user_i;
        if (expected_bins.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result with none expected, got real %0d imag %0d loud %0d",
                   $time, got_bin.re, got_bin.im, got_bin.loud);
        end else begin
          want_bin = expected_bins.pop_front();
          if (got_bin.re !== want_bin.re) begin
            flag_mismatch("real_out", want_bin.re, got_bin.re);
          end
          if (got_bin.im !== want_bin.im) begin
            flag_mismatch("imag_out", want_bin.im, got_bin.im);
          end
          if (got_bin.loud !== want_bin.loud) begin
            flag_mismatch("is_loud", want_bin.loud, got_bin.loud);
          end
          if (want_bin.loud) begin
            loud_count_o++;
          end else begin
            quiet_count_o++;
          end
        end
      end

      pending_o = expected_bins.size();
    end
  end

endmodule

FILE: tb/spectral_gate_bin_scaler_tb.sv
`timescale 1ns / 100ps
module spectral_gate_bin_scaler_tb;

  localparam int unsigned SW = sgbs_pkg::SAMPLE_W;
  localparam int unsigned IW = sgbs_pkg::IDX_W;

  localparam logic signed [SW-1:0] SAMPLE_MIN  = {1'b1, {(SW - 1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_MAX  = ~SAMPLE_MIN;
  localparam int                   PHASE_ITEMS = 190;
  localparam int                   FULL_LOADS  = 160;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [sgbs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [sgbs_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [sgbs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [sgbs_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [15:0]                     cfg_data_i = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count;
  int pending;
  int loud_count;
  int quiet_count;
  int loads_sent = 0;
  int reads_sent = 0;
  int settings_used = 0;

  bit            bin_written [sgbs_pkg::BINS];
  logic [IW-1:0] written_idx [$];
  logic [IW-1:0] frame_idx [$];

  spectral_gate_bin_scaler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  spectral_gate_bin_scaler_checker gate_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .loud_count_o  (loud_count),
    .quiet_count_o (quiet_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly values of random bit length so that bin powers span many decades.
  function automatic logic signed [SW-1:0] rand_sample();
    logic [SW-1:0] v;
    int            w;
    case ($urandom_range(0, 9))
      0: v = SW'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = SAMPLE_MIN;
          1: v = SAMPLE_MAX;
          2: v = '0;
          3: v = '1;
          default: v = SW'(1);
        endcase
      end
      default: begin
        w = $urandom_range(1, SW - 1);
        v = SW'($urandom_range(0, (1 << w) - 1));
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [IW-1:0] pick_written();
    return written_idx[$urandom_range(0, written_idx.size() - 1)];
  endfunction

  function automatic logic [IW-1:0] rand_idx();
    return IW'($urandom_range(0, sgbs_pkg::BINS - 1));
  endfunction

  task automatic send_bin(input logic act, input logic fs, input logic [IW-1:0] idx,
                          input logic signed [SW-1:0] re,
                          input logic signed [SW-1:0] im);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(sgbs_pkg::IN_DATA_W - IW - 2 * SW){1'b0}}, im, re, idx};
    s_axis_tuser <= {fs, act};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == sgbs_pkg::ACTION_LOAD) begin
      loads_sent++;
      if (!bin_written[idx]) begin
        bin_written[idx] = 1'b1;
        written_idx.push_back(idx);
      end
    end else begin
      reads_sent++;
    end
  endtask

  task automatic load_bin(input logic [IW-1:0] idx, input logic signed [SW-1:0] re,
                          input logic signed [SW-1:0] im, input logic fs);
    send_bin(sgbs_pkg::ACTION_LOAD, fs, idx, re, im);
  endtask

  task automatic read_bin(input logic [IW-1:0] idx, input logic fs);
    send_bin(sgbs_pkg::ACTION_READ, fs, idx, rand_sample(), rand_sample());
  endtask

  // Drops tvalid, waits for every outstanding read, then lets a load still in flight finish.
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [sgbs_pkg::CFG_IDX_W-1:0] reg_idx,
                           input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] gain, input logic [15:0] thresh);
    write_reg(sgbs_pkg::CFG_MIX_GAIN, gain);
    write_reg(sgbs_pkg::CFG_THRESH, thresh);
    settings_used++;
  endtask

  task automatic set_pace(input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic run_traffic(input int quota);
    int            first;
    int            n;
    int            kind;
    logic [IW-1:0] idx;
    first = loads_sent + reads_sent;
    while (loads_sent + reads_sent - first < quota) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(2, 16);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) begin
            load_bin(rand_idx(), rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
          end else begin
            read_bin(pick_written(), 1'($urandom_range(0, 1)));
          end
        end
      end else if (kind == 1) begin
        // No start marker: the power sum keeps growing on top of the previous frame.
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) != 0) begin
            load_bin(rand_idx(), rand_sample(), rand_sample(), 1'b0);
          end else begin
            read_bin(pick_written(), 1'b0);
          end
        end
      end else begin
        frame_idx.delete();
        for (int i = 0; i < n; i++) begin
          idx = rand_idx();
          load_bin(idx, rand_sample(), rand_sample(), i == 0);
          frame_idx.push_back(idx);
        end
        repeat ($urandom_range(1, n + 2)) begin
          read_bin(frame_idx[$urandom_range(0, frame_idx.size() - 1)],
                   $urandom_range(0, 9) == 0);
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        quiesce();
      end
    end
  endtask

  initial begin
    int          gains [8];
    int          threshs [8];
    int          full_thresh [4];
    logic [15:0] gain;
    logic [15:0] thresh;

    gains = '{32768, 0, 65535, 16384, -1, 40000, -1, 24576};
    threshs = '{3840, 65535, 0, 256, -1, 1, -1, 1024};
    full_thresh = '{65535, 256, 128, 0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero power with a zero sum counts as loud.
    load_bin(IW'(0), SW'(0), SW'(0), 1'b1);
    read_bin(IW'(0), 1'b0);
    load_bin(IW'(sgbs_pkg::BINS - 1), SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    load_bin(IW'(1), SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    load_bin(IW'(2), SW'(1), SW'(-1), 1'b0);
    load_bin(IW'(3), SW'(-1), SW'(0), 1'b0);
    load_bin(IW'(4), SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    read_bin(IW'(sgbs_pkg::BINS - 1), 1'b0);
    read_bin(IW'(1), 1'b0);
    read_bin(IW'(2), 1'b0);
    read_bin(IW'(3), 1'b1);
    read_bin(IW'(4), 1'b0);
    quiesce();
    // Gain above unity saturates; a zero threshold makes every bin loud.
    set_regs(16'hFFFF, 16'h0000);
    read_bin(IW'(2), 1'b0);
    read_bin(IW'(sgbs_pkg::BINS - 1), 1'b0);
    quiesce();
    set_regs(16'h0000, 16'hFFFF);
    read_bin(IW'(1), 1'b0);
    read_bin(IW'(3), 1'b0);
    quiesce();
    set_regs(16'd12345, sgbs_pkg::THR_RESET);
    read_bin(IW'(4), 1'b0);
    read_bin(IW'(2), 1'b0);
    read_bin(IW'(0), 1'b0);
    load_bin(IW'(5), SW'(100), SW'(-200), 1'b1);
    read_bin(IW'(5), 1'b0);
    read_bin(IW'(1), 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      quiesce();
      case (ph % 4)
        0: set_pace(0, 0);
        1: set_pace(60, 0);
        2: set_pace(0, 60);
        default: set_pace(30, 30);
      endcase
      gain = (gains[ph] < 0) ? 16'($urandom) : 16'(gains[ph]);
      thresh = (threshs[ph] < 0) ? 16'($urandom) : 16'(threshs[ph]);
      set_regs(gain, thresh);
      run_traffic(PHASE_ITEMS);
    end

    // One long frame of near full-scale bins builds a large power sum.
    quiesce();
    set_pace(0, 0);
    set_regs(sgbs_pkg::UNITY_GAIN, sgbs_pkg::THR_RESET);
    for (int i = 0; i < FULL_LOADS; i++) begin
      load_bin(IW'(i), (i % 3 == 0) ? SAMPLE_MAX : SAMPLE_MIN, SAMPLE_MIN, i == 0);
    end
    for (int k = 0; k < 4; k++) begin
      quiesce();
      set_pace(0, 60);
      set_regs(16'($urandom_range(0, 40000)), 16'(full_thresh[k]));
      repeat (6) read_bin(pick_written(), 1'b0);
      load_bin(rand_idx(), SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      load_bin(rand_idx(), rand_sample(), rand_sample(), 1'b0);
      repeat (2) read_bin(pick_written(), 1'b0);
    end

    quiesce();
    $display("Run covered %0d loads and %0d reads under %0d gain and threshold settings,",
             loads_sent, reads_sent, settings_used);
    $display("with %0d loud and %0d quiet results, idle and stall pacing, and a full-scale frame.",
             loud_count, quiet_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
